FILE: hdl/sdsse_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and the glyph table of the signed decimal seven-segment encoder
// no dependencies; used by sdsse_digit_stage, signed_decimal_seven_segment_encoder and the test files

package sdsse_pkg;

   // number of digits driven, and the fixed digit slots of the port
   localparam int DIGITS     = 4;
   localparam int MAX_DIGITS = 4;
   localparam int SEG_W      = 7;
   localparam int SEGS_W     = MAX_DIGITS * SEG_W;
   localparam int VALUE_W    = 16;
   localparam int CODE_W     = 4;

   // accepted range and magnitude width
   localparam int MAX_VALUE = (10 ** DIGITS) - 1;
   localparam int MIN_MAG   = MAX_VALUE / 10;
   localparam int MAG_W     = $clog2(MAX_VALUE + 1);

   // divide by ten as multiply by ceil(2^19 / 10), exact for inputs below 43690
   localparam int RECIP_TEN   = 52429;
   localparam int RECIP_W     = 16;
   localparam int RECIP_SHIFT = 19;
   localparam int PROD_W      = MAG_W + RECIP_W;

   // glyph code for the minus sign
   localparam logic [CODE_W-1:0] MINUS_CODE = 4'd10;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_TOO_LARGE = 2'd1,
      STATUS_TOO_SMALL = 2'd2
   } status_type;

   // one item as it moves down the pipeline
   typedef struct packed {
      logic                           valid;
      status_type                     status;
      logic                           neg;
      logic [MAG_W-1:0]               mag;
      logic [DIGITS-1:0][CODE_W-1:0]  digit;
   } stage_type;

   // segment pattern of one glyph, bit 0 is segment a
   function automatic logic [SEG_W-1:0] glyph(input logic [CODE_W-1:0] code);
      logic [SEG_W-1:0] pat;
      case (code)
         4'd0:       pat = 7'd63;
         4'd1:       pat = 7'd6;
         4'd2:       pat = 7'd91;
         4'd3:       pat = 7'd79;
         4'd4:       pat = 7'd102;
         4'd5:       pat = 7'd109;
         4'd6:       pat = 7'd125;
         4'd7:       pat = 7'd7;
         4'd8:       pat = 7'd127;
         4'd9:       pat = 7'd111;
         MINUS_CODE: pat = 7'd64;
         default:    pat = 7'd63;
      endcase
      return pat;
   endfunction

endpackage

FILE: hdl/signed_decimal_seven_segment_encoder.sv
`timescale 1ns / 1ps
// Signed decimal seven-segment encoder. Each transfer on req carries one signed 16-bit
// number; each transfer on rsp carries a status code, an update flag and 7 segment bits per
// digit. Values from -(10^(DIGITS-1)-1) to 10^DIGITS-1 are shown with leading zeros kept and
// a minus sign on the top digit; outside that range the status says too large or too small,
// update is low and all segments are zero. A new number is taken every cycle while rsp is not
// stalled; it passes through one input stage for range check and magnitude, one divide-by-ten
// stage per lower digit, and one output register for glyph lookup and common-anode inversion.
// The whole pipeline holds while rsp is stalled. The user must write the anode_mask register
// through csr only while the block is idle; the block itself does not enforce this.
// depends on sdsse_pkg and sdsse_digit_stage

module signed_decimal_seven_segment_encoder (
   input  logic        clock,
   input  logic        reset,
   // input stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,    // [15:0] value
   // result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,    // [27:0] segments, [31:28] zero
   output logic [2:0]  rsp_tuser,    // [1:0] status, [2] update
   // anode mask write
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [3:0]  csr_wdata     // [3:0] anode_mask
);

   localparam int DIGITS = sdsse_pkg::DIGITS;

   logic                                 enable;
   logic [3:0]                           anode_mask_ff;
   sdsse_pkg::stage_type                 in_stage_ff;
   sdsse_pkg::stage_type                 in_stage_in;
   sdsse_pkg::stage_type                 stage_w [DIGITS];
   logic signed [sdsse_pkg::VALUE_W:0]   value_ext;
   logic [sdsse_pkg::VALUE_W-1:0]        abs_value;
   logic                                 rsp_valid_ff;
   sdsse_pkg::status_type                rsp_status_ff;
   sdsse_pkg::status_type                rsp_status_in;
   logic                                 rsp_update_ff;
   logic                                 rsp_update_in;
   logic [sdsse_pkg::SEGS_W-1:0]         rsp_segments_ff;
   logic [sdsse_pkg::SEGS_W-1:0]         rsp_segments_in;
   logic [sdsse_pkg::CODE_W-1:0]         code;
   sdsse_pkg::stage_type                 last_stage;

   // whole pipeline moves when the output register is free or being taken
   assign enable     = !rsp_valid_ff || rsp_tready;
   assign req_tready = enable;
   assign csr_ready  = 1'b1;

   // anode mask register
   always_ff @(posedge clock) begin
      if (reset) begin
         anode_mask_ff <= 4'd0;
      end else if (csr_valid) begin
         anode_mask_ff <= csr_wdata;
      end
   end

   // input stage: range check and magnitude
   always_comb begin
      value_ext         = {req_tdata[15], req_tdata};
      abs_value         = req_tdata[15] ? (~req_tdata + 16'd1) : req_tdata;
      in_stage_in       = '0;
      in_stage_in.valid = req_tvalid;
      in_stage_in.neg   = req_tdata[15];
      in_stage_in.mag   = sdsse_pkg::MAG_W'(abs_value);
      if (value_ext > $signed(17'(sdsse_pkg::MAX_VALUE))) begin
         in_stage_in.status = sdsse_pkg::STATUS_TOO_LARGE;
      end else if (value_ext < -$signed(17'(sdsse_pkg::MIN_MAG))) begin
         in_stage_in.status = sdsse_pkg::STATUS_TOO_SMALL;
      end else begin
         in_stage_in.status = sdsse_pkg::STATUS_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_stage_ff.valid <= 1'b0;
      end else if (enable) begin
         in_stage_ff <= in_stage_in;
      end
   end

   assign stage_w[0] = in_stage_ff;

   // one divide-by-ten stage per lower digit
   for (genvar g = 1; g < DIGITS; g++) begin : g_digit
      sdsse_digit_stage u_stage (
         .clock   (clock),
         .reset   (reset),
         .enable  (enable),
         .stage_i (stage_w[g-1]),
         .stage_o (stage_w[g])
      );
   end

   assign last_stage = stage_w[DIGITS-1];

   // glyph lookup, top digit sign, common-anode inversion
   always_comb begin
      rsp_segments_in = '0;
      rsp_status_in   = last_stage.status;
      rsp_update_in   = (last_stage.status == sdsse_pkg::STATUS_OK);
      code            = '0;
      if (rsp_update_in) begin
         for (int p = 0; p < DIGITS; p++) begin
            if (p < DIGITS - 1) begin
               code = last_stage.digit[p+1];
            end else if (last_stage.neg) begin
               code = sdsse_pkg::MINUS_CODE;
            end else begin
               code = sdsse_pkg::CODE_W'(last_stage.mag);
            end
            rsp_segments_in[p*sdsse_pkg::SEG_W +: sdsse_pkg::SEG_W] =
               sdsse_pkg::glyph(code) ^ {sdsse_pkg::SEG_W{anode_mask_ff[p]}};
         end
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (enable) begin
         rsp_valid_ff    <= last_stage.valid;
         rsp_status_ff   <= rsp_status_in;
         rsp_update_ff   <= rsp_update_in;
         rsp_segments_ff <= rsp_segments_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'd0, rsp_segments_ff};
   assign rsp_tuser  = {rsp_update_ff, rsp_status_ff};

   // update is raised exactly for an in-range number
   a_update_status : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_update_ff == (rsp_status_ff == sdsse_pkg::STATUS_OK)))
      else $error("update flag does not match status");

   // a rejected number drives no segments
   a_reject_blank : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_update_ff) |-> (rsp_segments_ff == '0))
      else $error("segments set on out-of-range result");

   // an accepted transfer shows up in the input stage with its range verdict
   a_input_capture : assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (in_stage_ff.valid &&
         ((in_stage_ff.status == sdsse_pkg::STATUS_OK) ==
          ($signed($past(req_tdata)) <= sdsse_pkg::MAX_VALUE &&
           $signed($past(req_tdata)) >= -sdsse_pkg::MIN_MAG))))
      else $error("input stage lost or misjudged a transfer");

   // a stalled output holds the pipeline behind it
   a_stall_hold : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |=> $stable(last_stage))
      else $error("pipeline moved during a stall");

endmodule

FILE: hdl/sdsse_digit_stage.sv
`timescale 1ns / 1ps
// one pipeline stage that splits off the lowest decimal digit of the magnitude
// depends on sdsse_pkg

module sdsse_digit_stage (
   input  logic                clock,
   input  logic                reset,
   input  logic                enable,
   input  sdsse_pkg::stage_type stage_i,
   output sdsse_pkg::stage_type stage_o
);

   sdsse_pkg::stage_type                stage_ff;
   sdsse_pkg::stage_type                stage_in;
   logic [sdsse_pkg::PROD_W-1:0]        prod;
   logic [sdsse_pkg::MAG_W-1:0]         quot;
   logic [sdsse_pkg::MAG_W-1:0]         quot_x10;
   logic [sdsse_pkg::CODE_W-1:0]        rem;

   // quotient by reciprocal multiply, remainder by shift-add back
   always_comb begin
      prod     = sdsse_pkg::PROD_W'(stage_i.mag) *
                 sdsse_pkg::PROD_W'(sdsse_pkg::RECIP_TEN);
      quot     = sdsse_pkg::MAG_W'(prod >> sdsse_pkg::RECIP_SHIFT);
      quot_x10 = (quot << 3) + (quot << 1);
      rem      = sdsse_pkg::CODE_W'(stage_i.mag - quot_x10);
   end

   // new digit enters at the top of the digit list, older ones move down
   always_comb begin
      stage_in       = stage_i;
      stage_in.mag   = quot;
      stage_in.digit = {rem, stage_i.digit[sdsse_pkg::DIGITS-1:1]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else if (enable) begin
         stage_ff <= stage_in;
      end
   end

   assign stage_o = stage_ff;

endmodule

FILE: test/sdsse_display_checker.sv
`timescale 1ns / 1ps
// checker of the signed decimal seven-segment encoder: watches the req, rsp and csr channels,
// predicts the digit patterns of every accepted number and compares them in order
// depends on sdsse_pkg

module sdsse_display_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [15:0] req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [31:0] rsp_tdata,
   input  logic [2:0]  rsp_tuser,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [3:0]  csr_wdata,
   output int          mismatch_count,
   output int          open_count
);

   // one predicted display update
   typedef struct {
      sdsse_pkg::status_type        status;
      logic                         update;
      logic [sdsse_pkg::SEGS_W-1:0] segments;
      logic [15:0]                  number;
   } display_type;

   // segment patterns of the digits 0 to 9 and the minus sign, bit 0 is segment a
   localparam logic [sdsse_pkg::SEG_W-1:0] SEG_FONT [0:10] = '{
      7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F, 7'h40
   };

   display_type pending_displays [$];
   display_type due;
   logic [3:0]  anode_copy;
   int          rsp_index;

   initial begin
      mismatch_count = 0;
      open_count     = 0;
      anode_copy     = '0;
      rsp_index      = 0;
   end

   // expected patterns for one number under the given anode mask
   function automatic display_type predict_display(input logic [15:0] raw,
                                                   input logic [3:0] mask);
      display_type                  d;
      int                           v;
      int                           top;
      int                           mag;
      logic [sdsse_pkg::SEG_W-1:0]  pat;
      d.status   = sdsse_pkg::STATUS_OK;
      d.update   = 1'b1;
      d.segments = '0;
      d.number   = raw;
      v   = $signed(raw);
      top = (10 ** sdsse_pkg::DIGITS) - 1;
      if (v > top) begin
         d.status = sdsse_pkg::STATUS_TOO_LARGE;
         d.update = 1'b0;
      end else if (v < -(top / 10)) begin
         d.status = sdsse_pkg::STATUS_TOO_SMALL;
         d.update = 1'b0;
      end else begin
         mag = (v < 0) ? -v : v;
         for (int pos = 0; pos < sdsse_pkg::DIGITS; pos++) begin
            // top digit carries the sign of a negative number
            if (pos == sdsse_pkg::DIGITS - 1 && v < 0)
               pat = SEG_FONT[sdsse_pkg::MINUS_CODE];
            else
               pat = SEG_FONT[mag % 10];
            mag = mag / 10;
            if (mask[pos])
               pat = ~pat;
            d.segments[pos*sdsse_pkg::SEG_W +: sdsse_pkg::SEG_W] = pat;
         end
      end
      return d;
   endfunction

   task automatic report_mismatch(input string field, input int got, input int want,
                                  input logic [15:0] number);
      $display("mismatch in rsp transfer %0d (value %0d): %s got 0x%0h, want 0x%0h",
               rsp_index, $signed(number), field, got, want);
      mismatch_count++;
   endtask

   // track the mask, queue predictions, compare results in order
   always @(posedge clock) begin
      if (reset) begin
         pending_displays.delete();
         anode_copy = '0;
      end else begin
         if (csr_valid && csr_ready)
            anode_copy = csr_wdata;
         if (req_tvalid && req_tready)
            pending_displays.push_back(predict_display(req_tdata, anode_copy));
         if (rsp_tvalid && rsp_tready) begin
            if (pending_displays.size() == 0) begin
               $display("rsp transfer %0d arrived with no number pending", rsp_index);
               mismatch_count++;
            end else begin
               due = pending_displays.pop_front();
               if (rsp_tuser[1:0] != due.status)
                  report_mismatch("status", rsp_tuser[1:0], due.status, due.number);
               if (rsp_tuser[2] != due.update)
                  report_mismatch("update", rsp_tuser[2], due.update, due.number);
               if (rsp_tdata[sdsse_pkg::SEGS_W-1:0] != due.segments)
                  report_mismatch("segments", rsp_tdata[sdsse_pkg::SEGS_W-1:0],
                                  due.segments, due.number);
               if (rsp_tdata[31:sdsse_pkg::SEGS_W] != '0)
                  report_mismatch("padding", rsp_tdata[31:sdsse_pkg::SEGS_W], 0,
                                  due.number);
            end
            rsp_index++;
         end
      end
      open_count <= pending_displays.size();
   end

endmodule

FILE: test/signed_decimal_seven_segment_encoder_tb.sv
`timescale 1ns / 1ps
// testbench of the signed decimal seven-segment encoder: directed and random numbers under
// several anode masks, with random idling on both streams; checking is in sdsse_display_checker
// depends on sdsse_pkg, sdsse_display_checker and signed_decimal_seven_segment_encoder

module signed_decimal_seven_segment_encoder_tb;

   localparam int RANDOM_PER_PHASE = 292;
   localparam int STALL_LIMIT      = 5000;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic [2:0]  rsp_tuser;
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic [3:0]  csr_wdata  = '0;

   int   mismatch_count;
   int   open_count;
   int   quiet_cycles = 0;
   logic steady       = 1'b0;

   signed_decimal_seven_segment_encoder dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_wdata  (csr_wdata)
   );

   sdsse_display_checker checker_inst (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .open_count     (open_count)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // receiver stalls about a quarter of the cycles, except in the steady stretch
   always @(posedge clock) begin
      rsp_tready <= steady || ($urandom_range(0, 99) >= 25);
   end

   // watchdog on cycles with no transfer on any channel
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // one number on req, with a random gap before it
   task automatic send_number(input logic [15:0] number);
      while (!steady && $urandom_range(0, 99) < 25) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= number;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
   endtask

   // wait until every pending result is back
   task automatic drain_pipeline();
      req_tvalid <= 1'b0;
      do
         @(posedge clock);
      while (open_count != 0);
      repeat (sdsse_pkg::DIGITS + 3) @(posedge clock);
   endtask

   task automatic write_anode_mask(input logic [3:0] mask);
      csr_valid <= 1'b1;
      csr_wdata <= mask;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   // mostly in-range numbers, some near the range ends, some anywhere in 16 bits
   function automatic logic [15:0] pick_number();
      int top;
      int low;
      int v;
      top = (10 ** sdsse_pkg::DIGITS) - 1;
      low = -(top / 10);
      case ($urandom_range(0, 9))
         0, 1: v = $urandom_range(0, 65535);
         2:    v = ($urandom_range(0, 1) ? top : low) + $urandom_range(0, 4) - 2;
         default: v = $urandom_range(0, top - low) + low;
      endcase
      return v[15:0];
   endfunction

   task automatic run_random_phase(input logic [3:0] mask);
      drain_pipeline();
      write_anode_mask(mask);
      repeat (RANDOM_PER_PHASE) send_number(pick_number());
   endtask

   logic [15:0] edge_numbers [0:19] = '{
      16'd0, 16'd9999, 16'd10000, -16'sd999, -16'sd1000, 16'd32767, 16'h8000, -16'sd1,
      16'd1, 16'd1234, 16'd5678, 16'd9876, -16'sd123, -16'sd45, -16'sd9, 16'd8,
      16'd1000, 16'd999, -16'sd100, 16'd10
   };

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // range ends, every digit and the minus sign, all digits inverted
      write_anode_mask(4'hF);
      foreach (edge_numbers[i])
         send_number(edge_numbers[i]);

      run_random_phase(4'h0);
      steady = 1'b1;
      run_random_phase(4'h5);
      steady = 1'b0;
      run_random_phase(4'hA);
      repeat (3) run_random_phase(4'($urandom_range(0, 15)));

      drain_pipeline();
      if (mismatch_count == 0 && open_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
